>>> rtl/ufb_pkg.sv
// ----------------------------------------------------------------------------
// ufb_pkg
// Shared types and constants of the USLP transfer frame builder.
// ----------------------------------------------------------------------------
`default_nettype none

package ufb_pkg;

  localparam int DATA_W     = 8;
  localparam int LEN_W      = 16;
  localparam int GMAP_W     = 30;
  localparam int S_TDATA_W  = 56;
  localparam int S_TUSER_W  = 2;
  localparam int M_TUSER_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  // s_tdata layout
  localparam int TD_DATA_LSB = 0;
  localparam int TD_LEN_LSB  = 8;
  localparam int TD_GMAP_LSB = 24;
  // s_tuser layout
  localparam int TU_FIRST = 0;
  localparam int TU_EXPED = 1;

  // gmap_address layout
  localparam int GM_MAP_LSB  = 0;
  localparam int GM_VCID_LSB = 4;
  localparam int GM_SCID_LSB = 10;
  localparam int GM_VER_LSB  = 26;

  localparam int CHANNEL_COUNT = 64;
  localparam int CH_W          = 6;
  localparam int CNT_W         = 8;

  localparam int TOTAL_W          = LEN_W + 1;
  localparam int MAX_FRAME_OCTETS = 4096;
  localparam logic [TOTAL_W-1:0] MAX_FRAME   = TOTAL_W'(MAX_FRAME_OCTETS);
  localparam logic [TOTAL_W-1:0] OVERHEAD    = TOTAL_W'(12);
  localparam logic [LEN_W-1:0]   FLEN_OFFSET = LEN_W'(11);

  localparam int HDR_OCTETS = 9;
  localparam logic [DATA_W-1:0] HDR_BYPASS_OCTET = 8'h81;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_VERSION  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_DEST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RULE     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PROTO    = 2'd3;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_VER  = 2'd1,
    ST_SEQ_CTRL = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_e;

  typedef struct packed {
    logic                                 err;
    status_e                              status;
    logic                                 hdr;
    logic [HDR_OCTETS-1:0][DATA_W-1:0]    hdr_bytes;
    logic                                 data_v;
    logic [DATA_W-1:0]                    data;
    logic                                 crc_v;
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/ufb_ram.sv
// ----------------------------------------------------------------------------
// ufb_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ufb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/ufb_front.sv
// ----------------------------------------------------------------------------
// ufb_front
// Accept SDU items, check the first item, keep the channel frame counters
// and issue one frame command per item that produces output.
// ----------------------------------------------------------------------------
`default_nettype none

module ufb_front (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [ufb_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [ufb_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [ufb_pkg::S_TDATA_W-1:0]     s_tdata,
  input  wire logic [ufb_pkg::S_TUSER_W-1:0]     s_tuser,
  input  wire logic                              s_tlast,
  output logic                                   cmd_valid_o,
  output ufb_pkg::cmd_t                          cmd_o,
  input  wire logic                              cmd_full_i
);

  logic [3:0] exp_ver_q;
  logic       src_dest_q;
  logic [2:0] rule_q;
  logic [4:0] proto_q;

  logic                              b_vld_q;
  logic [ufb_pkg::DATA_W-1:0]        b_data_q;
  logic [ufb_pkg::LEN_W-1:0]         b_len_q;
  logic [ufb_pkg::GMAP_W-1:0]        b_gmap_q;
  logic                              b_first_q, b_last_q, b_exped_q;

  logic                              drop_q, drop_d;
  logic                              open_q, open_d;
  logic [ufb_pkg::LEN_W-1:0]         left_q, left_d;

  logic [ufb_pkg::CHANNEL_COUNT-1:0] cnt_vld_q;
  logic                              rd_vld_q;
  logic                              fwd_q;
  logic [ufb_pkg::CNT_W-1:0]         fwd_val_q;
  logic [ufb_pkg::CNT_W-1:0]         ram_rdata;

  logic                              accept, b_fire, push, cnt_we;
  logic [ufb_pkg::CH_W-1:0]          in_ch, b_ch;
  logic [ufb_pkg::CNT_W-1:0]         cnt_rd, cnt_wr;
  logic [3:0]                        ver;
  logic [15:0]                       scid;
  logic [5:0]                        vcid;
  logic [3:0]                        map_id;
  logic [ufb_pkg::TOTAL_W-1:0]       total;
  logic [ufb_pkg::LEN_W-1:0]         flen;
  ufb_pkg::status_e                  st;
  ufb_pkg::cmd_t                     cmd;

  assign accept   = s_tvalid && s_tready;
  assign b_fire   = b_vld_q && !cmd_full_i;
  assign s_tready = !b_vld_q || b_fire;

  assign in_ch = s_tdata[ufb_pkg::TD_GMAP_LSB + ufb_pkg::GM_VCID_LSB +: ufb_pkg::CH_W];

  assign ver    = b_gmap_q[ufb_pkg::GM_VER_LSB  +: 4];
  assign scid   = b_gmap_q[ufb_pkg::GM_SCID_LSB +: 16];
  assign vcid   = b_gmap_q[ufb_pkg::GM_VCID_LSB +: 6];
  assign map_id = b_gmap_q[ufb_pkg::GM_MAP_LSB  +: 4];
  assign b_ch   = vcid[ufb_pkg::CH_W-1:0];

  assign cnt_rd = fwd_q ? fwd_val_q : (rd_vld_q ? ram_rdata : '0);
  assign cnt_wr = cnt_rd + ufb_pkg::CNT_W'(1);
  assign total  = {1'b0, b_len_q} + ufb_pkg::OVERHEAD;
  assign flen   = b_len_q + ufb_pkg::FLEN_OFFSET;

  always_comb begin
    cmd       = '0;
    cmd.data  = b_data_q;
    push      = 1'b0;
    cnt_we    = 1'b0;
    st        = ufb_pkg::ST_OK;
    drop_d    = drop_q;
    open_d    = open_q;
    left_d    = left_q;
    if (b_first_q) begin
      drop_d = 1'b0;
      open_d = 1'b0;
      left_d = '0;
      if (ver != exp_ver_q) begin
        st = ufb_pkg::ST_BAD_VER;
      end else if (!b_exped_q) begin
        st = ufb_pkg::ST_SEQ_CTRL;
      end else begin
        cnt_we = 1'b1;
        if (total > ufb_pkg::MAX_FRAME) begin
          st = ufb_pkg::ST_TOO_LONG;
        end
      end
      push = 1'b1;
      if (st != ufb_pkg::ST_OK) begin
        cmd.err    = 1'b1;
        cmd.status = st;
        drop_d     = !b_last_q;
      end else begin
        cmd.hdr          = 1'b1;
        cmd.hdr_bytes[0] = {ver, scid[15:12]};
        cmd.hdr_bytes[1] = scid[11:4];
        cmd.hdr_bytes[2] = {scid[3:0], src_dest_q, vcid[5:3]};
        cmd.hdr_bytes[3] = {vcid[2:0], map_id, 1'b0};
        cmd.hdr_bytes[4] = flen[15:8];
        cmd.hdr_bytes[5] = flen[7:0];
        cmd.hdr_bytes[6] = ufb_pkg::HDR_BYPASS_OCTET;
        cmd.hdr_bytes[7] = cnt_rd;
        cmd.hdr_bytes[8] = {rule_q, proto_q};
        cmd.data_v       = (b_len_q != '0);
        cmd.crc_v        = b_last_q;
        open_d           = !b_last_q;
        left_d           = b_last_q ? '0 : b_len_q - ufb_pkg::LEN_W'(cmd.data_v);
      end
    end else if (drop_q) begin
      if (b_last_q) begin
        drop_d = 1'b0;
      end
    end else if (open_q) begin
      cmd.data_v = (left_q != '0);
      cmd.crc_v  = b_last_q;
      push       = cmd.data_v || b_last_q;
      left_d     = left_q - ufb_pkg::LEN_W'(cmd.data_v);
      if (b_last_q) begin
        open_d = 1'b0;
        left_d = '0;
      end
    end
  end

  assign cmd_valid_o = b_fire && push;
  assign cmd_o       = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_ver_q  <= 4'd12;
      src_dest_q <= 1'b0;
      rule_q     <= 3'd7;
      proto_q    <= 5'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ufb_pkg::CFG_VERSION:  exp_ver_q  <= cfg_data_i[3:0];
        ufb_pkg::CFG_SRC_DEST: src_dest_q <= cfg_data_i[0];
        ufb_pkg::CFG_RULE:     rule_q     <= cfg_data_i[2:0];
        ufb_pkg::CFG_PROTO:    proto_q    <= cfg_data_i[4:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q   <= 1'b0;
      drop_q    <= 1'b0;
      open_q    <= 1'b0;
      left_q    <= '0;
      cnt_vld_q <= '0;
      rd_vld_q  <= 1'b0;
      fwd_q     <= 1'b0;
      fwd_val_q <= '0;
    end else begin
      if (b_fire) begin
        drop_q <= drop_d;
        open_q <= open_d;
        left_q <= left_d;
        if (cnt_we) begin
          cnt_vld_q[b_ch] <= 1'b1;
        end
      end
      if (accept) begin
        b_vld_q   <= 1'b1;
        rd_vld_q  <= cnt_vld_q[in_ch];
        fwd_q     <= b_fire && cnt_we && (b_ch == in_ch);
        fwd_val_q <= cnt_wr;
      end else if (b_fire) begin
        b_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_data_q  <= s_tdata[ufb_pkg::TD_DATA_LSB +: ufb_pkg::DATA_W];
      b_len_q   <= s_tdata[ufb_pkg::TD_LEN_LSB  +: ufb_pkg::LEN_W];
      b_gmap_q  <= s_tdata[ufb_pkg::TD_GMAP_LSB +: ufb_pkg::GMAP_W];
      b_first_q <= s_tuser[ufb_pkg::TU_FIRST];
      b_exped_q <= s_tuser[ufb_pkg::TU_EXPED];
      b_last_q  <= s_tlast;
    end
  end

  ufb_ram #(
    .WIDTH (ufb_pkg::CNT_W),
    .DEPTH (ufb_pkg::CHANNEL_COUNT)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (b_fire && cnt_we),
    .waddr_i (b_ch),
    .wdata_i (cnt_wr),
    .re_i    (accept),
    .raddr_i (in_ch),
    .rdata_o (ram_rdata)
  );

  a_drop_not_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drop_q |-> !open_q)
    else $error("dropping while a frame is open");

  a_left_only_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !open_q |-> left_q == '0)
    else $error("data octets pending without an open frame");

endmodule

`default_nettype wire

>>> rtl/ufb_cmd_fifo.sv
// ----------------------------------------------------------------------------
// ufb_cmd_fifo
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module ufb_cmd_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire ufb_pkg::cmd_t push_data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output ufb_pkg::cmd_t      pop_data_o
);

  ufb_pkg::cmd_t                 mem_q [ufb_pkg::FIFO_DEPTH];
  logic [ufb_pkg::FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [ufb_pkg::FIFO_CNT_W-1:0] cnt_q;
  logic                           do_push, do_pop;

  assign full_o     = (cnt_q == ufb_pkg::FIFO_CNT_W'(ufb_pkg::FIFO_DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + ufb_pkg::FIFO_CNT_W'(do_push) - ufb_pkg::FIFO_CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("command pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("command popped from an empty queue");

endmodule

`default_nettype wire

>>> rtl/ufb_back.sv
// ----------------------------------------------------------------------------
// ufb_back
// Run frame commands: header, data, CRC or error octets, one per unstalled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ufb_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cmd_valid_i,
  input  wire ufb_pkg::cmd_t                 cmd_i,
  output logic                               cmd_pop_o,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [ufb_pkg::DATA_W-1:0]         m_tdata,
  output logic [ufb_pkg::M_TUSER_W-1:0]      m_tuser,
  output logic                               m_tlast
);

  localparam logic [3:0] STEP_HDR_LAST = 4'd8;
  localparam logic [3:0] STEP_DATA     = 4'd9;
  localparam logic [3:0] STEP_CRC_HI   = 4'd10;
  localparam logic [3:0] STEP_CRC_LO   = 4'd11;
  localparam logic [3:0] STEP_ERR      = 4'd12;
  localparam logic [3:0] STEP_DONE     = 4'd15;

  function automatic logic [15:0] crc_upd(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      r = r[15] ? ({r[14:0], 1'b0} ^ 16'h1021) : {r[14:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [3:0] step_start(input ufb_pkg::cmd_t c);
    priority if (c.err)    return STEP_ERR;
    else if (c.hdr)        return 4'd0;
    else if (c.data_v)     return STEP_DATA;
    else if (c.crc_v)      return STEP_CRC_HI;
    else                   return STEP_DONE;
  endfunction

  function automatic logic [3:0] step_after(input ufb_pkg::cmd_t c, input logic [3:0] s);
    priority if (s < STEP_HDR_LAST)  return s + 4'd1;
    else if (s == STEP_HDR_LAST)     return c.data_v ? STEP_DATA
                                          : (c.crc_v ? STEP_CRC_HI : STEP_DONE);
    else if (s == STEP_DATA)         return c.crc_v ? STEP_CRC_HI : STEP_DONE;
    else if (s == STEP_CRC_HI)       return STEP_CRC_LO;
    else                             return STEP_DONE;
  endfunction

  ufb_pkg::cmd_t               cur_q, cur_d;
  logic                        cur_v_q, cur_v_d;
  logic [3:0]                  step_q, step_d, nxt;
  logic [15:0]                 crc_q, crc_d, crc_in;
  logic                        out_free, emit;
  logic [ufb_pkg::DATA_W-1:0]  byte_d;
  logic                        end_d;
  ufb_pkg::status_e            st_d;
  logic                        m_tvalid_q;
  logic [ufb_pkg::DATA_W-1:0]  m_tdata_q;
  logic                        m_tlast_q;
  ufb_pkg::status_e            m_st_q;

  assign out_free = !m_tvalid_q || m_tready;
  assign emit     = cur_v_q && out_free;
  assign nxt      = step_after(cur_q, step_q);
  assign crc_in   = (step_q == 4'd0) ? 16'hFFFF : crc_q;

  always_comb begin
    byte_d = '0;
    end_d  = 1'b0;
    st_d   = ufb_pkg::ST_OK;
    crc_d  = crc_q;
    if (step_q <= STEP_HDR_LAST) begin
      byte_d = cur_q.hdr_bytes[step_q];
      crc_d  = crc_upd(crc_in, byte_d);
    end else if (step_q == STEP_DATA) begin
      byte_d = cur_q.data;
      crc_d  = crc_upd(crc_q, byte_d);
    end else if (step_q == STEP_CRC_HI) begin
      byte_d = crc_q[15:8];
    end else if (step_q == STEP_CRC_LO) begin
      byte_d = crc_q[7:0];
      end_d  = 1'b1;
    end else begin
      end_d = 1'b1;
      st_d  = cur_q.status;
    end
  end

  always_comb begin
    cur_d     = cur_q;
    cur_v_d   = cur_v_q;
    step_d    = step_q;
    cmd_pop_o = 1'b0;
    if (!cur_v_q || (emit && nxt == STEP_DONE)) begin
      cmd_pop_o = cmd_valid_i;
      cur_v_d   = cmd_valid_i;
      cur_d     = cmd_i;
      step_d    = step_start(cmd_i);
    end else if (emit) begin
      step_d = nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_v_q    <= 1'b0;
      step_q     <= STEP_DONE;
      m_tvalid_q <= 1'b0;
    end else begin
      cur_v_q <= cur_v_d;
      step_q  <= step_d;
      if (emit) begin
        m_tvalid_q <= 1'b1;
      end else if (m_tready) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (emit) begin
      crc_q     <= crc_d;
      m_tdata_q <= byte_d;
      m_tlast_q <= end_d;
      m_st_q    <= st_d;
    end
  end

  assign m_tvalid = m_tvalid_q;
  assign m_tdata  = m_tdata_q;
  assign m_tlast  = m_tlast_q;
  assign m_tuser  = m_st_q;

  a_step_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_v_q |-> step_q != STEP_DONE)
    else $error("active command with no step left");

  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_q && m_st_q != ufb_pkg::ST_OK) |-> (m_tlast_q && m_tdata_q == '0))
    else $error("error result not a single closing zero octet");

endmodule

`default_nettype wire

>>> rtl/uslp_frame_builder.sv
// ----------------------------------------------------------------------------
// uslp_frame_builder
// USLP transfer frame builder with CRC-16 frame error control.
// ----------------------------------------------------------------------------
// Path: input register, command queue, command register, output register.
// Throughput: one input item per cycle unless the queue is full; one output octet
//   per cycle unless stalled; an n-octet SDU's frame is n + 11 (9 header, 2 CRC).
// The 4-entry command queue lets input and output stall independently.
// Reset: asynchronous, active low; channel frame counters read as zero through
//   per-channel valid flags, no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module uslp_frame_builder (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [ufb_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [ufb_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // data_byte[7:0], sdu_length[23:8], gmap_address[53:24], zero[55:54]
  input  wire logic [ufb_pkg::S_TDATA_W-1:0]     s_tdata,
  // first_byte[0], expedited[1]
  input  wire logic [ufb_pkg::S_TUSER_W-1:0]     s_tuser,
  input  wire logic                              s_tlast,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // frame_byte[7:0]
  output logic [ufb_pkg::DATA_W-1:0]             m_tdata,
  // status[1:0]
  output logic [ufb_pkg::M_TUSER_W-1:0]          m_tuser,
  output logic                                   m_tlast
);

  logic          push, full, pop, q_valid;
  ufb_pkg::cmd_t push_cmd, pop_cmd;

  ufb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .s_tlast     (s_tlast),
    .cmd_valid_o (push),
    .cmd_o       (push_cmd),
    .cmd_full_i  (full)
  );

  ufb_cmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_cmd)
  );

  ufb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (pop_cmd),
    .cmd_pop_o   (pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

endmodule

`default_nettype wire

>>> test/tb_uslp_frame_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uslp_frame_builder
// Self-checking bench for the USLP transfer frame builder.
// SDUs are streamed in as first/last-marked byte runs: short directed cases,
// then random well-formed SDUs mixed with broken runs and stray bytes, under
// several register settings and idle patterns. A behavioural model predicts
// each frame octet, and every output transfer is compared in order. One phase
// holds the output off for a long stretch so that the input must stall.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_uslp_frame_builder;
  import ufb_pkg::*;

  localparam logic [15:0] CRC_PRESET     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'h1021;
  localparam logic [16:0] FRAME_OVERHEAD = 17'd12;
  localparam logic [16:0] FRAME_LIMIT    = 17'd4096;
  localparam logic [7:0]  BYPASS_OCTET   = 8'h81;
  localparam int          DRAIN_CYCLES   = 16;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          CYCLE_LIMIT    = 400000;
  localparam int          PHASE_ITEMS    = 40;

  typedef struct packed {
    logic [7:0]  data;
    logic        first;
    logic        last;
    logic [15:0] len;
    logic [29:0] gmap;
    logic        exped;
  } sdu_item_t;

  typedef struct packed {
    logic [7:0] value;
    logic       fend;
    status_e    st;
  } frame_octet_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata;
  logic [S_TUSER_W-1:0]  s_tuser;
  logic                  s_tlast;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [DATA_W-1:0]     m_tdata;
  logic [M_TUSER_W-1:0]  m_tuser;
  logic                  m_tlast;

  uslp_frame_builder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

  // Frame model state and register copies
  logic [3:0]  cfg_version;
  logic        cfg_src_dest;
  logic [2:0]  cfg_rule;
  logic [4:0]  cfg_proto;
  logic [7:0]  frame_count [CHANNEL_COUNT];
  logic [15:0] frame_crc;
  logic        dropping;
  logic        frame_open;
  logic [15:0] data_left;

  frame_octet_t octets_due[$];

  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;
  logic        hold_active   = 1'b0;
  event        hold_off_start;

  int items_sent      = 0;
  int noise_items     = 0;
  int frames_built    = 0;
  int sdus_rejected   = 0;
  int octets_checked  = 0;
  int error_count     = 0;
  int stalled_cycles  = 0;
  int cycle_count     = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------- model
  function automatic logic [15:0] crc_after_octet(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    return r;
  endfunction

  task automatic push_octet(input logic [7:0] value, input logic fend, input status_e st);
    frame_octet_t o;
    o.value = value;
    o.fend  = fend;
    o.st    = st;
    octets_due.push_back(o);
  endtask

  task automatic emit_octet(input logic [7:0] value);
    frame_crc = crc_after_octet(frame_crc, value);
    push_octet(value, 1'b0, ST_OK);
  endtask

  task automatic predict_frame_octets(input sdu_item_t it);
    logic [3:0]  ver;
    logic [15:0] scid;
    logic [5:0]  vcid;
    logic [3:0]  map_id;
    logic [16:0] total;
    logic [15:0] flen;
    logic [7:0]  count;
    status_e     st;
    logic        go_on;
    go_on  = 1'b1;
    ver    = it.gmap[GM_VER_LSB +: 4];
    scid   = it.gmap[GM_SCID_LSB +: 16];
    vcid   = it.gmap[GM_VCID_LSB +: 6];
    map_id = it.gmap[GM_MAP_LSB +: 4];
    total  = {1'b0, it.len} + FRAME_OVERHEAD;
    count  = 8'h00;
    if (it.first) begin
      frame_open = 1'b0;
      dropping   = 1'b0;
      data_left  = 16'd0;
      st = ST_OK;
      if (ver != cfg_version) begin
        st = ST_BAD_VER;
      end else if (!it.exped) begin
        st = ST_SEQ_CTRL;
      end else begin
        count = frame_count[vcid];
        frame_count[vcid] = count + 8'd1;
        if (total > FRAME_LIMIT) st = ST_TOO_LONG;
      end
      if (st != ST_OK) begin
        push_octet(8'h00, 1'b1, st);
        dropping = !it.last;
        sdus_rejected++;
        go_on = 1'b0;
      end else begin
        flen = total[15:0] - 16'd1;
        frame_crc = CRC_PRESET;
        emit_octet({ver, scid[15:12]});
        emit_octet(scid[11:4]);
        emit_octet({scid[3:0], cfg_src_dest, vcid[5:3]});
        emit_octet({vcid[2:0], map_id, 1'b0});
        emit_octet(flen[15:8]);
        emit_octet(flen[7:0]);
        emit_octet(BYPASS_OCTET);
        emit_octet(count);
        emit_octet({cfg_rule, cfg_proto});
        frame_open = 1'b1;
        data_left  = it.len;
        frames_built++;
      end
    end else if (dropping) begin
      if (it.last) dropping = 1'b0;
      go_on = 1'b0;
    end else if (!frame_open) begin
      go_on = 1'b0;
    end
    if (go_on) begin
      if (data_left != 16'd0) begin
        emit_octet(it.data);
        data_left--;
      end
      if (it.last) begin
        push_octet(frame_crc[15:8], 1'b0, ST_OK);
        push_octet(frame_crc[7:0], 1'b1, ST_OK);
        frame_open = 1'b0;
        data_left  = 16'd0;
        frame_crc  = CRC_PRESET;
      end
    end
  endtask

  // -------------------------------------------------------------- checker
  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("[%0t] %s", $time, msg);
  endtask

  always @(posedge clk_i) begin : check_octets
    frame_octet_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      octets_checked++;
      if (octets_due.size() == 0) begin
        report_error($sformatf("unexpected octet %02h last %0b status %0d",
                               m_tdata, m_tlast, m_tuser));
      end else begin
        want = octets_due.pop_front();
        if (m_tdata !== want.value || m_tlast !== want.fend || m_tuser !== want.st)
          report_error($sformatf("octet %0d: expected %02h/%0b/%0d got %02h/%0b/%0d",
                                 octets_checked, want.value, want.fend, want.st,
                                 m_tdata, m_tlast, m_tuser));
      end
    end
  end

  // ------------------------------------------------------------- receiver
  always @(negedge clk_i) begin
    if (hold_active && s_tvalid && !s_tready) stalled_cycles++;
    m_tready <= !hold_active && ($urandom_range(99) >= sink_idle_pct);
  end

  always begin
    @(hold_off_start);
    @(posedge clk_i);
    hold_active = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_active = 1'b0;
  end

  // --------------------------------------------------------------- sender
  function automatic sdu_item_t make_item(input logic [7:0] data, input logic first,
                                          input logic last, input logic [15:0] len,
                                          input logic [29:0] gmap, input logic exped);
    sdu_item_t it;
    it.data  = data;
    it.first = first;
    it.last  = last;
    it.len   = len;
    it.gmap  = gmap;
    it.exped = exped;
    return it;
  endfunction

  function automatic logic [29:0] gmap_of(input logic [3:0] ver, input logic [15:0] scid,
                                          input logic [5:0] vcid, input logic [3:0] map_id);
    return {ver, scid, vcid, map_id};
  endfunction

  function automatic logic [29:0] random_gmap();
    logic [29:0] g;
    g = 30'($urandom);
    if ($urandom_range(9) != 0) g[GM_VER_LSB +: 4] = cfg_version;
    return g;
  endfunction

  task automatic send_item(input sdu_item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, it.gmap, it.len, it.data};
    s_tuser  <= {it.exped, it.first};
    s_tlast  <= it.last;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    predict_frame_octets(it);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_sdu(input logic [29:0] gmap, input logic exped, input logic [15:0] len,
                          input int n_items, input logic closed);
    for (int i = 0; i < n_items; i++)
      send_item(make_item(8'($urandom), i == 0, closed && (i == n_items - 1),
                          (i == 0) ? len : 16'($urandom), (i == 0) ? gmap : 30'($urandom),
                          (i == 0) ? exped : 1'($urandom)));
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(3, 1);
    for (int i = 0; i < n; i++)
      send_item(make_item(8'($urandom), 1'b0, 1'($urandom), 16'($urandom),
                          30'($urandom), 1'($urandom)));
    noise_items += n;
  endtask

  task automatic write_config(input logic [3:0] ver, input logic sd, input logic [2:0] rule,
                              input logic [4:0] proto);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_VERSION;
    cfg_data_i <= CFG_DATA_W'(ver);
    @(negedge clk_i);
    cfg_idx_i  <= CFG_SRC_DEST;
    cfg_data_i <= CFG_DATA_W'(sd);
    @(negedge clk_i);
    cfg_idx_i  <= CFG_RULE;
    cfg_data_i <= CFG_DATA_W'(rule);
    @(negedge clk_i);
    cfg_idx_i  <= CFG_PROTO;
    cfg_data_i <= CFG_DATA_W'(proto);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_version  = ver;
    cfg_src_dest = sd;
    cfg_rule     = rule;
    cfg_proto    = proto;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (octets_due.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    logic [29:0] ok_gmap;
    src_idle_pct  = 17;
    sink_idle_pct = 86;
    ok_gmap = gmap_of(cfg_version, 16'h1234, 6'd9, 4'd5);
    send_item(make_item(8'h00, 1'b1, 1'b0, 16'd3, gmap_of(cfg_version, 16'h0000, 6'd0, 4'd0),
                        1'b1));
    send_item(make_item(8'hFF, 1'b0, 1'b0, 16'hFFFF, 30'h3FFFFFFF, 1'b0));
    send_item(make_item(8'h5A, 1'b0, 1'b1, 16'h0000, 30'h0, 1'b1));
    send_item(make_item(8'hFF, 1'b1, 1'b1, 16'd1, gmap_of(cfg_version, 16'hFFFF, 6'h3F, 4'hF),
                        1'b1));
    // zero length: data byte of the first transfer is not passed
    send_item(make_item(8'hC3, 1'b1, 1'b1, 16'd0, ok_gmap, 1'b1));
    send_sdu(gmap_of(cfg_version ^ 4'h9, 16'h00FF, 6'd2, 4'd1), 1'b1, 16'd5, 3, 1'b1);
    send_sdu(ok_gmap, 1'b0, 16'd2, 1, 1'b1);
    send_sdu(ok_gmap, 1'b1, 16'd4085, 2, 1'b1);
    send_sdu(ok_gmap, 1'b1, 16'd4084, 2, 1'b1);
    send_sdu(ok_gmap, 1'b1, 16'hFFFF, 1, 1'b1);
    send_sdu(ok_gmap, 1'b1, 16'd1, 3, 1'b1);
    send_item(make_item(8'h77, 1'b0, 1'b1, 16'd3, ok_gmap, 1'b1));
    // abandon an open frame with a fresh first transfer
    send_sdu(ok_gmap, 1'b1, 16'd4, 2, 1'b0);
    send_sdu(ok_gmap, 1'b1, 16'd1, 1, 1'b1);
    send_sdu(ok_gmap, 1'b1, 16'd0, 2, 1'b1);
  endtask

  task automatic test_random_phase(input int unsigned src_pct, input int unsigned sink_pct,
                                   input logic [3:0] ver, input logic sd,
                                   input logic [2:0] rule, input logic [4:0] proto);
    int          start;
    int unsigned pick;
    int          len;
    int          n;
    logic        closed;
    wait_drained();
    write_config(ver, sd, rule, proto);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    start = items_sent - noise_items;
    while ((items_sent - noise_items) - start < PHASE_ITEMS) begin
      pick   = $urandom_range(99);
      len    = $urandom_range(12);
      n      = (len == 0) ? 1 : len;
      closed = 1'b1;
      if (pick < 6) begin
        len = $urandom_range(65535, 4085);
        n   = $urandom_range(3, 1);
      end else if (pick < 10) begin
        len = $urandom_range(4084, 4000);
        n   = $urandom_range(4, 1);
      end else if (pick < 15) begin
        n = n + $urandom_range(3, 1);
      end else if (pick < 20) begin
        len = len + $urandom_range(5, 1);
      end else if (pick < 25) begin
        closed = 1'b0;
      end
      if (pick >= 92) send_noise();
      else send_sdu(random_gmap(), $urandom_range(15) != 0, 16'(len), n, closed);
    end
  endtask

  task automatic test_counter_wrap();
    logic [29:0] g;
    for (int i = 0; i < 256; i++) begin
      g = gmap_of(cfg_version, 16'($urandom), 6'd37, 4'($urandom));
      send_sdu(g, 1'b1, 16'($urandom_range(65535, 4085)), 1, 1'b1);
    end
    send_sdu(gmap_of(cfg_version, 16'hBEEF, 6'd37, 4'd3), 1'b1, 16'd2, 2, 1'b1);
  endtask

  task automatic test_back_pressure();
    wait_drained();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    -> hold_off_start;
    send_sdu(gmap_of(cfg_version, 16'h0F0F, 6'd11, 4'd7), 1'b1, 16'd48, 48, 1'b1);
    send_sdu(gmap_of(cfg_version, 16'hF0F0, 6'd12, 4'd8), 1'b1, 16'd5, 5, 1'b1);
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = '0;
    s_tlast      = 1'b0;
    cfg_version  = 4'd12;
    cfg_src_dest = 1'b0;
    cfg_rule     = 3'd7;
    cfg_proto    = 5'd0;
    frame_crc    = CRC_PRESET;
    dropping     = 1'b0;
    frame_open   = 1'b0;
    data_left    = 16'd0;
    for (int i = 0; i < CHANNEL_COUNT; i++) frame_count[i] = 8'h00;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    write_config(4'd12, 1'b0, 3'd7, 5'd0);
    test_directed();
    test_random_phase(17, 86, 4'd15, 1'b1, 3'd0, 5'd31);
    test_random_phase(86, 17, 4'd0, 1'b0, 3'd7, 5'd0);
    test_random_phase(0, 0, 4'd12, 1'b1, 3'd3, 5'd17);
    test_counter_wrap();
    test_back_pressure();
    wait_drained();
    $display("Run covered %0d input transfers: %0d frames built, %0d SDUs rejected,",
             items_sent, frames_built, sdus_rejected);
    $display("%0d octets checked, four register settings, a frame counter wrap and %0d %s",
             octets_checked, stalled_cycles, "input stall cycles under hold-off.");
    if (error_count == 0 && octets_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d octets still awaited", error_count, octets_due.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire
